/* src/khms_pkg.sv */
package khms_pkg;

   localparam int THREADS_DEF = 4;
   localparam int PLIES_DEF = 256;
   localparam int HIST_ENTRIES = 768;
   localparam int HIX_W = 10;

   localparam logic [15:0] HISTORY_LIMIT_RST = 16'd16384;
   localparam logic [15:0] TOTAL_LIMIT_RST = 16'd16384;
   localparam logic signed [15:0] TRANS_SCORE = 16'sd32766;
   localparam logic signed [15:0] KILLER_TOP = 16'sd4;
   localparam logic signed [17:0] QUIET_BASE = -18'sd24000;
   localparam logic [16:0] WEIGHT_MAX = 17'h1FFFF;
   localparam logic [15:0] COUNT_MAX = 16'hFFFF;
   localparam logic [6:0] SQUARES = 7'd64;

   localparam logic [2:0] KIND_CUTOFF = 3'd0;
   localparam logic [2:0] KIND_SUCCESS = 3'd1;
   localparam logic [2:0] KIND_FAILURE = 3'd2;
   localparam logic [2:0] KIND_SCORE = 3'd3;
   localparam logic [2:0] KIND_KILLER = 3'd4;

   localparam logic CSR_HISTORY_LIMIT = 1'b0;
   localparam logic CSR_TOTAL_LIMIT = 1'b1;

   typedef struct packed {
      logic [2:0] kind;
      logic [15:0] move_code;
      logic [3:0] piece_index;
      logic [5:0] target_square;
      logic [6:0] search_depth;
      logic [7:0] ply;
      logic [15:0] hash_move;
      logic [1:0] thread_id;
      logic is_tactical;
   } req_type;

   typedef struct packed {
      logic signed [15:0] order_score;
      logic [15:0] hit_ratio;
      logic [15:0] killer_first;
      logic [15:0] killer_second;
      logic [15:0] killer_third;
      logic [15:0] killer_fourth;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_READ,
      ST_READ2,
      ST_EXEC,
      ST_SWEEP_RD,
      ST_SWEEP_WR,
      ST_DIV,
      ST_OUT
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic clear_step;
      logic load;
      logic read_a;
      logic read_b;
      logic exec;
      logic sweep_rd;
      logic sweep_wr;
      logic div_step;
      logic out_load;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic clear_done;
      logic need_sweep;
      logic need_div;
      logic has_rsp;
      logic sweep_done;
      logic div_done;
   } sts_type;

endpackage

/* src/khms_ctrl.sv */
module khms_ctrl (
   input logic clock,
   input logic reset,
   input logic req_valid,
   output logic req_ready,
   output logic rsp_valid,
   input logic rsp_ready,
   output khms_pkg::cmd_type cmd,
   input khms_pkg::sts_type sts
);

   khms_pkg::state_type state_ff, state_in;
   logic rsp_valid_ff, rsp_valid_in;

   // state and output flag
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= khms_pkg::ST_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   // next state and commands
   always_comb begin
      state_in = state_ff;
      cmd = '0;
      req_ready = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      case (state_ff)
         khms_pkg::ST_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (sts.clear_done) state_in = khms_pkg::ST_IDLE;
         end
         khms_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = khms_pkg::ST_READ;
            end
         end
         khms_pkg::ST_READ: begin
            cmd.read_a = 1'b1;
            state_in = khms_pkg::ST_READ2;
         end
         khms_pkg::ST_READ2: begin
            cmd.read_b = 1'b1;
            state_in = khms_pkg::ST_EXEC;
         end
         khms_pkg::ST_EXEC: begin
            cmd.exec = 1'b1;
            if (sts.need_sweep) state_in = khms_pkg::ST_SWEEP_RD;
            else if (sts.need_div) state_in = khms_pkg::ST_DIV;
            else if (sts.has_rsp) state_in = khms_pkg::ST_OUT;
            else state_in = khms_pkg::ST_IDLE;
         end
         khms_pkg::ST_SWEEP_RD: begin
            cmd.sweep_rd = 1'b1;
            state_in = khms_pkg::ST_SWEEP_WR;
         end
         khms_pkg::ST_SWEEP_WR: begin
            cmd.sweep_wr = 1'b1;
            if (sts.sweep_done) state_in = khms_pkg::ST_IDLE;
            else state_in = khms_pkg::ST_SWEEP_RD;
         end
         khms_pkg::ST_DIV: begin
            // stop stepping once all quotient bits are in
            if (sts.div_done) state_in = khms_pkg::ST_OUT;
            else cmd.div_step = 1'b1;
         end
         khms_pkg::ST_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.out_load = 1'b1;
               rsp_valid_in = 1'b1;
               state_in = khms_pkg::ST_IDLE;
            end
         end
         default: state_in = khms_pkg::ST_IDLE;
      endcase
   end

endmodule

/* src/khms_datapath.sv */
module khms_datapath #(
   parameter int THREADS = khms_pkg::THREADS_DEF,
   parameter int PLIES = khms_pkg::PLIES_DEF
) (
   input logic clock,
   input logic reset,
   input khms_pkg::req_type req,
   input logic csr_write,
   input logic csr_index,
   input logic [15:0] csr_data,
   input khms_pkg::cmd_type cmd,
   output khms_pkg::sts_type sts,
   output khms_pkg::rsp_type rsp
);

   localparam int TW = (THREADS > 1) ? $clog2(THREADS) : 1;
   localparam int PW = $clog2(PLIES);
   localparam int ROWS = THREADS * PLIES;
   localparam int RW = $clog2(ROWS);
   localparam int CW = (RW > khms_pkg::HIX_W) ? RW : khms_pkg::HIX_W;
   localparam int HW = khms_pkg::HIX_W;
   localparam logic [HW-1:0] HLAST = HW'(khms_pkg::HIST_ENTRIES - 1);

   // memories: killer rows hold both slots
   logic [31:0] kmem [ROWS];
   logic [16:0] wmem [khms_pkg::HIST_ENTRIES];
   logic [15:0] hmem [khms_pkg::HIST_ENTRIES];
   logic [15:0] tmem [khms_pkg::HIST_ENTRIES];

   logic [15:0] hlim_ff, tlim_ff;
   khms_pkg::req_type r_ff;
   logic [CW-1:0] clr_ff;
   logic [HW-1:0] swp_ff;
   logic [PW-1:0] ply_mod [256];
   logic [TW-1:0] thr_mod [4];
   logic [PW-1:0] ply_row;
   logic [TW-1:0] thr_row;
   logic [RW-1:0] row0, row2;
   logic [HW-1:0] hix;
   logic hvalid, up;
   logic [31:0] k0_ff, k2_ff;
   logic [16:0] w_ff, sw_ff;
   logic [15:0] h_ff, t_ff;
   logic [16:0] w_new;
   logic [17:0] w_sum;
   logic [15:0] h_inc, t_inc;
   logic signed [15:0] score_ff;
   logic [31:0] dividend_ff;
   logic [15:0] divisor_ff;
   logic [16:0] rem_ff;
   logic [5:0] dcnt_ff;
   logic [16:0] rem_sh;
   logic [15:0] a, b, c, d;
   logic signed [18:0] quiet;

   // constant tables for ply and thread wrap-around
   for (genvar g = 0; g < 256; g++) begin : g_ply_mod
      assign ply_mod[g] = PW'(g % PLIES);
   end
   for (genvar g = 0; g < 4; g++) begin : g_thr_mod
      assign thr_mod[g] = TW'(g % THREADS);
   end

   // index arithmetic
   assign ply_row = ply_mod[r_ff.ply];
   assign thr_row = thr_mod[r_ff.thread_id];
   assign row0 = RW'(32'(thr_row) * 32'(PLIES) + 32'(ply_row));
   assign row2 = RW'(32'(thr_row) * 32'(PLIES) + 32'(ply_row) - 32'd2);
   assign up = ply_row > PW'(2);
   assign hix = HW'({r_ff.piece_index, r_ff.target_square});
   assign hvalid = r_ff.piece_index < 4'd12;

   // configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         hlim_ff <= khms_pkg::HISTORY_LIMIT_RST;
         tlim_ff <= khms_pkg::TOTAL_LIMIT_RST;
      end else if (csr_write) begin
         if (csr_index == khms_pkg::CSR_HISTORY_LIMIT) hlim_ff <= csr_data;
         else tlim_ff <= csr_data;
      end
   end

   // request capture and counters
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= '0;
      end else if (cmd.clear_step) begin
         clr_ff <= clr_ff + 1'b1;
      end
      if (cmd.load) r_ff <= req;
      if (cmd.exec) swp_ff <= '0;
      else if (cmd.sweep_wr) swp_ff <= swp_ff + 1'b1;
   end

   assign sts.clear_done = (clr_ff == CW'(ROWS - 1) || ROWS - 1 < khms_pkg::HIST_ENTRIES)
                           && clr_ff >= CW'(ROWS - 1) && clr_ff >= CW'(HLAST);
   assign sts.sweep_done = swp_ff == HLAST;

   // update arithmetic
   assign w_sum = 18'(w_ff) + 18'(r_ff.search_depth) * 18'(r_ff.search_depth);
   assign w_new = w_sum[17] ? khms_pkg::WEIGHT_MAX : w_sum[16:0];
   assign h_inc = (r_ff.kind == khms_pkg::KIND_SUCCESS && h_ff != khms_pkg::COUNT_MAX)
                  ? h_ff + 16'd1 : h_ff;
   assign t_inc = (t_ff != khms_pkg::COUNT_MAX) ? t_ff + 16'd1 : t_ff;

   assign sts.need_sweep = r_ff.kind == khms_pkg::KIND_CUTOFF && !r_ff.is_tactical
                           && hvalid && w_new >= 17'(hlim_ff);
   assign sts.need_div = r_ff.kind == khms_pkg::KIND_SCORE;
   assign sts.has_rsp = r_ff.kind == khms_pkg::KIND_KILLER;

   // memory ports
   always_ff @(posedge clock) begin
      if (cmd.clear_step) begin
         if (32'(clr_ff) < 32'(ROWS)) kmem[clr_ff[RW-1:0]] <= '0;
         if (clr_ff < CW'(khms_pkg::HIST_ENTRIES)) begin
            wmem[clr_ff[HW-1:0]] <= '0;
            hmem[clr_ff[HW-1:0]] <= 16'd1;
            tmem[clr_ff[HW-1:0]] <= 16'd1;
         end
      end
      if (cmd.read_a) begin
         k0_ff <= kmem[row0];
         w_ff <= hvalid ? wmem[hix] : '0;
         h_ff <= hvalid ? hmem[hix] : 16'd1;
         t_ff <= hvalid ? tmem[hix] : 16'd1;
      end
      if (cmd.read_b) k2_ff <= up ? kmem[row2] : '0;
      if (cmd.exec) begin
         if (r_ff.kind == khms_pkg::KIND_CUTOFF && !r_ff.is_tactical) begin
            if (k0_ff[15:0] != r_ff.move_code) kmem[row0] <= {k0_ff[15:0], r_ff.move_code};
            if (hvalid) wmem[hix] <= w_new;
         end
         if ((r_ff.kind == khms_pkg::KIND_SUCCESS || r_ff.kind == khms_pkg::KIND_FAILURE)
             && hvalid) begin
            if (t_inc >= tlim_ff) begin
               hmem[hix] <= 16'((17'(h_inc) + 17'd1) >> 1);
               tmem[hix] <= 16'((17'(t_inc) + 17'd1) >> 1);
            end else begin
               hmem[hix] <= h_inc;
               tmem[hix] <= t_inc;
            end
         end
      end
      if (cmd.sweep_rd) sw_ff <= wmem[swp_ff];
      if (cmd.sweep_wr && sw_ff >= 17'd2)
         wmem[swp_ff] <= 17'((18'(sw_ff) + 18'd1) >> 1);
   end

   // score
   assign quiet = 19'(khms_pkg::QUIET_BASE) + 19'(w_ff);
   always_ff @(posedge clock) begin
      if (cmd.exec) begin
         if (r_ff.move_code != 0 && r_ff.move_code == r_ff.hash_move)
            score_ff <= khms_pkg::TRANS_SCORE;
         else if (r_ff.is_tactical) score_ff <= '0;
         else if (r_ff.move_code != 0 && r_ff.move_code == k0_ff[15:0])
            score_ff <= khms_pkg::KILLER_TOP;
         else if (r_ff.move_code != 0 && r_ff.move_code == k0_ff[31:16])
            score_ff <= khms_pkg::KILLER_TOP - 16'sd2;
         else if (r_ff.move_code != 0 && up && r_ff.move_code == k2_ff[15:0])
            score_ff <= khms_pkg::KILLER_TOP - 16'sd1;
         else if (r_ff.move_code != 0 && up && r_ff.move_code == k2_ff[31:16])
            score_ff <= khms_pkg::KILLER_TOP - 16'sd3;
         else if (quiet > 19'(khms_pkg::TRANS_SCORE)) score_ff <= khms_pkg::TRANS_SCORE;
         else score_ff <= quiet[15:0];
      end
   end

   // restoring divider, one quotient bit a cycle
   assign rem_sh = {rem_ff[15:0], dividend_ff[31]};
   always_ff @(posedge clock) begin
      if (cmd.exec) begin
         dividend_ff <= h_ff * hlim_ff;
         divisor_ff <= t_ff;
         rem_ff <= '0;
         dcnt_ff <= '0;
      end else if (cmd.div_step) begin
         dcnt_ff <= dcnt_ff + 6'd1;
         if (rem_sh >= 17'(divisor_ff)) begin
            rem_ff <= rem_sh - 17'(divisor_ff);
            dividend_ff <= {dividend_ff[30:0], 1'b1};
         end else begin
            rem_ff <= rem_sh;
            dividend_ff <= {dividend_ff[30:0], 1'b0};
         end
      end
   end
   assign sts.div_done = dcnt_ff == 6'd32;

   // dedup killers
   always_comb begin
      a = k0_ff[15:0];
      c = k0_ff[31:16];
      b = k2_ff[15:0];
      d = k2_ff[31:16];
      if (a != 0) begin
         if (b == a) b = '0;
         if (c == a) c = '0;
         if (d == a) d = '0;
      end
      if (b != 0) begin
         if (c == b) c = '0;
         if (d == b) d = '0;
      end
      if (d == c) d = '0;
   end

   // output register
   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         if (r_ff.kind == khms_pkg::KIND_SCORE) begin
            rsp.order_score <= score_ff;
            rsp.hit_ratio <= (divisor_ff == 0 || dividend_ff[31:16] != 0)
                             ? khms_pkg::COUNT_MAX : dividend_ff[15:0];
            rsp.killer_first <= '0;
            rsp.killer_second <= '0;
            rsp.killer_third <= '0;
            rsp.killer_fourth <= '0;
         end else begin
            rsp.order_score <= '0;
            rsp.hit_ratio <= '0;
            rsp.killer_first <= a;
            rsp.killer_second <= b;
            rsp.killer_third <= c;
            rsp.killer_fourth <= d;
         end
      end
   end

endmodule

/* src/killer_history_move_scorer.sv */
// Updates: READ, READ2 and EXEC follow acceptance before the next request is taken.
// Killer query: valid after READ, READ2, EXEC and OUT; score queries add the 32-step
// divider for the hit ratio. The next request can be taken once the result is valid,
// unless an earlier result still waits. A cutoff that reaches the limit adds a halving
// sweep over the history table. Reset clears control state, then a clearing pass over
// max(THREADS*PLIES, 768) rows initialises all tables before the first request is taken.
module killer_history_move_scorer #(
   parameter int THREADS = khms_pkg::THREADS_DEF,
   parameter int PLIES = khms_pkg::PLIES_DEF
) (
   input logic clock,
   input logic reset,
   input logic req_valid,
   output logic req_ready,
   input khms_pkg::req_type req_data,
   output logic rsp_valid,
   input logic rsp_ready,
   output khms_pkg::rsp_type rsp_data,
   input logic csr_write,
   input logic csr_index,
   input logic [15:0] csr_data
);

   khms_pkg::cmd_type cmd;
   khms_pkg::sts_type sts;

   khms_ctrl u_ctrl (
      .clock(clock), .reset(reset), .req_valid(req_valid), .req_ready(req_ready),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .cmd(cmd), .sts(sts)
   );

   khms_datapath #(.THREADS(THREADS), .PLIES(PLIES)) u_dp (
      .clock(clock), .reset(reset), .req(req_data), .csr_write(csr_write),
      .csr_index(csr_index), .csr_data(csr_data), .cmd(cmd), .sts(sts), .rsp(rsp_data)
   );

endmodule

/* src/khms_checker.sv */
module khms_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input khms_pkg::rsp_type rsp_data
);

   // held response stays stable
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("response changed while stalled");

   // a request is never taken in the cycle after one
   a_seq: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("back to back request accepted");

   // score responses with a nonzero hit ratio carry no first killer
   a_score: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.hit_ratio != 0 |-> rsp_data.killer_first == 0)
      else $error("mixed response");

endmodule

bind killer_history_move_scorer khms_checker u_chk (
   .clock(clock), .reset(reset), .req_valid(req_valid), .req_ready(req_ready),
   .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
);
